// ----- hw/rtl/u2u_pkg.sv -----
package u2u_pkg;

    // Default depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int CP_W     = 21;
    localparam int OFFSET_W = 32;

    // Largest code point for the one-, two- and three-byte UTF-8 lengths, and the first supplementary code point.
    localparam logic [CP_W-1:0] MAX_1BYTE = 21'h00007F;
    localparam logic [CP_W-1:0] MAX_2BYTE = 21'h0007FF;
    localparam logic [CP_W-1:0] MAX_3BYTE = 21'h00FFFF;
    localparam logic [CP_W-1:0] SUPP_BASE = 21'h010000;

    // Top six bits of a surrogate unit.
    localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
    localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

    // UTF-8 lead and continuation markers.
    localparam logic [1:0] CONT_TAG  = 2'b10;
    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;
    localparam logic [4:0] LEAD4_TAG = 5'b11110;

    // One classified request handed from the front to the back.
    typedef struct packed {
        logic                is_err;
        logic [CP_W-1:0]     cp;
        logic [OFFSET_W-1:0] offset;
    } u2u_entry_t;

    // Number of UTF-8 bytes minus one for a code point.
    function automatic logic [1:0] utf8_last_pos(input logic [CP_W-1:0] cp);
        logic [1:0] r;
        if (cp <= MAX_1BYTE) begin
            r = 2'd0;
        end else if (cp <= MAX_2BYTE) begin
            r = 2'd1;
        end else if (cp <= MAX_3BYTE) begin
            r = 2'd2;
        end else begin
            r = 2'd3;
        end
        return r;
    endfunction

    // UTF-8 byte at position pos of the encoding of cp.
    function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
                                             input logic [1:0] pos);
        logic [7:0] b;
        logic [1:0] lp;
        lp = utf8_last_pos(cp);
        case (lp)
            2'd0: b = cp[7:0];
            2'd1: b = (pos == 2'd0) ? {LEAD2_TAG, cp[10:6]} : {CONT_TAG, cp[5:0]};
            2'd2:
            begin
                case (pos)
                    2'd0:    b = {LEAD3_TAG, cp[15:12]};
                    2'd1:    b = {CONT_TAG, cp[11:6]};
                    default: b = {CONT_TAG, cp[5:0]};
                endcase
            end
            default:
            begin
                case (pos)
                    2'd0:    b = {LEAD4_TAG, cp[20:18]};
                    2'd1:    b = {CONT_TAG, cp[17:12]};
                    2'd2:    b = {CONT_TAG, cp[11:6]};
                    default: b = {CONT_TAG, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

// ----- hw/rtl/utf16_to_utf8_transcoder.sv -----
// The completing byte's request is registered in the queue, then in the output register.
// Throughput: one input byte per cycle while the queue has room; the back sends one
// UTF-8 byte per cycle while the queue holds a request and the output is not stalled.
// Reset (rst_n, asynchronous, active low) clears pairing state, byte counter, queue,
// output valid and selects little-endian order.
module utf16_to_utf8_transcoder #(
    parameter int QUEUE_DEPTH = u2u_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        last,
    output logic        error,
    output logic [31:0] error_offset
);
    import u2u_pkg::*;

    // Front side of the queue: the front pushes one classified request per
    // completed unit that produces output (a data code point or an error).
    logic       push;
    u2u_entry_t push_entry;
    logic       q_full;

    // Back side of the queue: the back expands the head request into UTF-8
    // bytes and pops it once its final byte has gone into the output register.
    logic       pop;
    logic       q_not_empty;
    u2u_entry_t head;

    // The front pairs bytes into units, pairs surrogates and counts bytes.
    u2u_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // The queue lets the front keep taking bytes while the back drains a
    // multi-byte code point or waits on a stalled output.
    u2u_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .not_empty  (q_not_empty),
        .head       (head)
    );

    // The back owns the output register, so a result waiting on out_ready
    // stops the front from accepting input only once the queue is full.
    u2u_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .last         (last),
        .error        (error),
        .error_offset (error_offset)
    );

endmodule

// ----- hw/rtl/u2u_front.sv -----
module u2u_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                q_full,
    output logic                push,
    output u2u_pkg::u2u_entry_t push_entry
);
    import u2u_pkg::*;

    logic                big_endian_reg;
    logic                have_first_reg, have_first_next;
    logic [7:0]          first_byte_reg, first_byte_next;
    logic                pending_reg, pending_next;
    logic [9:0]          high_bits_reg, high_bits_next;
    logic [OFFSET_W-1:0] byte_index_reg, byte_index_next;
    logic                accept;
    logic [15:0]         unit;
    logic                is_high;
    logic                is_low;

    // A first byte never produces a request, so it is taken even when full.
    assign in_ready = !q_full || !have_first_reg;
    assign accept   = in_valid && in_ready;

    assign unit    = big_endian_reg ? {first_byte_reg, in_byte} : {in_byte, first_byte_reg};
    assign is_high = (unit[15:10] == HIGH_SURR_TAG);
    assign is_low  = (unit[15:10] == LOW_SURR_TAG);

    always_comb
    begin
        have_first_next   = have_first_reg;
        first_byte_next   = first_byte_reg;
        pending_next      = pending_reg;
        high_bits_next    = high_bits_reg;
        byte_index_next   = byte_index_reg;
        push              = 1'b0;
        push_entry.is_err = 1'b0;
        push_entry.cp     = {5'd0, unit};
        push_entry.offset = byte_index_reg;
        if (accept) begin
            if (byte_index_reg != {OFFSET_W{1'b1}}) begin
                byte_index_next = byte_index_reg + 1'b1;
            end
            if (!have_first_reg) begin
                have_first_next = 1'b1;
                first_byte_next = in_byte;
            end else begin
                have_first_next = 1'b0;
                if (pending_reg) begin
                    // Either a complete pair or a broken one; both clear the pairing.
                    push              = 1'b1;
                    push_entry.is_err = !is_low;
                    push_entry.cp     = {1'b0, high_bits_reg, unit[9:0]} + SUPP_BASE;
                    pending_next      = 1'b0;
                    high_bits_next    = 10'd0;
                end else if (is_high) begin
                    pending_next   = 1'b1;
                    high_bits_next = unit[9:0];
                end else begin
                    push              = 1'b1;
                    push_entry.is_err = is_low;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            big_endian_reg <= 1'b0;
            have_first_reg <= 1'b0;
            first_byte_reg <= 8'd0;
            pending_reg    <= 1'b0;
            high_bits_reg  <= 10'd0;
            byte_index_reg <= '0;
        end else begin
            if (cfg_we) begin
                big_endian_reg <= cfg_wdata;
            end
            have_first_reg <= have_first_next;
            first_byte_reg <= first_byte_next;
            pending_reg    <= pending_next;
            high_bits_reg  <= high_bits_next;
            byte_index_reg <= byte_index_next;
        end
    end

endmodule

// ----- hw/rtl/u2u_queue.sv -----
module u2u_queue #(
    parameter int DEPTH = u2u_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  u2u_pkg::u2u_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output u2u_pkg::u2u_entry_t head
);
    import u2u_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    u2u_entry_t      entries_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- hw/rtl/u2u_back.sv -----
module u2u_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_not_empty,
    input  u2u_pkg::u2u_entry_t head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                last,
    output logic                error,
    output logic [31:0]         error_offset
);
    import u2u_pkg::*;

    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_byte_reg;
    logic                last_reg;
    logic                error_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic [1:0]          pos_reg, pos_next;
    logic                load;
    logic                final_byte;

    assign load       = q_not_empty && (!out_valid_reg || out_ready);
    assign final_byte = head.is_err || (pos_reg == utf8_last_pos(head.cp));
    assign pop        = load && final_byte;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        pos_next       = pos_reg;
        if (load) begin
            out_valid_next = 1'b1;
            pos_next       = final_byte ? 2'd0 : pos_reg + 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            out_byte_reg <= head.is_err ? 8'd0 : utf8_byte(head.cp, pos_reg);
            last_reg     <= final_byte;
            error_reg    <= head.is_err;
            offset_reg   <= head.is_err ? head.offset : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            pos_reg       <= 2'd0;
        end else begin
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign last         = last_reg;
    assign error        = error_reg;
    assign error_offset = offset_reg;

endmodule

// ----- hw/rtl/u2u_checker.sv -----
module u2u_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  out_byte,
    input logic        last,
    input logic        error,
    input logic [31:0] error_offset
);

    // A stalled request stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output request dropped while stalled");

    // A stalled request keeps its byte.
    a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_byte))
        else $error("output byte changed while stalled");

    // An error is always a single, final request with a zero byte.
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> last && (out_byte == 8'd0))
        else $error("error request is not a lone zero byte");

    // Data requests carry no offset.
    a_data_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !error |-> (error_offset == 32'd0))
        else $error("data request carries an offset");

    // A byte that ends a code point is never a lead byte of a longer sequence.
    a_last_not_lead: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last && !error |-> (out_byte[7:6] != 2'b11))
        else $error("final byte is a UTF-8 lead byte");

endmodule

bind utf16_to_utf8_transcoder u2u_checker u_chk (.*);
